// ===== rtl/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
`default_nettype none
package ole_pkg;

   localparam int CAPACITY = 16;
   localparam int IW       = $clog2(CAPACITY);
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int XW       = CW + 1;
   localparam int POS_W    = 5;
   localparam int CMPW     = (CW > POS_W) ? CW : POS_W;
   localparam int VAL_W    = 32;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 48;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_READ   = 2'd1,
      OP_REMOVE = 2'd2,
      OP_SEARCH = 2'd3
   } ole_op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } ole_status_type;

   typedef struct packed {
      logic capture;
      logic append;
      logic set_miss;
      logic set_full;
      logic start_read;
      logic start_shift;
      logic start_search;
      logic shift_step;
      logic search_step;
      logic take_read;
      logic take_found;
      logic dec_count;
      logic publish;
   } ole_cmd_type;

   typedef struct packed {
      ole_op_type op;
      logic       pos_ok;
      logic       shift_more;
      logic       full;
      logic       empty;
      logic       shift_cont;
      logic       search_more;
      logic       match;
   } ole_sts_type;

endpackage
`default_nettype wire

// ===== rtl/ole_dpath.sv =====
// Datapath of the ordered list engine: entry memory, count, walk index and result registers.
`default_nettype none
module ole_dpath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [ole_pkg::REQ_W-1:0] req_tdata,
   input  wire ole_pkg::ole_cmd_type      cmd,
   output ole_pkg::ole_sts_type           sts,
   output logic [ole_pkg::RSP_W-1:0]      rsp_tdata
);
   import ole_pkg::*;

   logic [VAL_W-1:0] mem [CAPACITY];
   logic [VAL_W-1:0] rdata_ff;
   logic [IW-1:0]    raddr;
   logic             wen;
   logic [IW-1:0]    waddr;
   logic [VAL_W-1:0] wdata;

   ole_op_type       op_ff;
   logic [POS_W-1:0] pos_ff;
   logic [VAL_W-1:0] key_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [IW-1:0]    idx_ff, idx_in;
   ole_status_type   res_status_ff, res_status_in;
   logic [VAL_W-1:0] res_read_ff, res_read_in;
   logic [POS_W-1:0] res_found_ff, res_found_in;
   logic [RSP_W-1:0] rsp_data_ff;

   logic [XW-1:0]    idx_x, count_x;

   assign idx_x   = XW'(idx_ff);
   assign count_x = XW'(count_ff);

   always_comb begin
      sts.op          = op_ff;
      sts.pos_ok      = (pos_ff != '0) && (CMPW'(pos_ff) <= CMPW'(count_ff));
      sts.shift_more  = CMPW'(pos_ff) < CMPW'(count_ff);
      sts.full        = count_ff == CW'(CAPACITY);
      sts.empty       = count_ff == '0;
      sts.shift_cont  = (idx_x + XW'(2)) < count_x;
      sts.search_more = (idx_x + XW'(1)) < count_x;
      sts.match       = rdata_ff == key_ff;
   end

   always_comb begin
      raddr = idx_ff + IW'(1);
      if (cmd.start_read) begin
         raddr = IW'(pos_ff - POS_W'(1));
      end else if (cmd.start_shift) begin
         raddr = IW'(pos_ff);
      end else if (cmd.start_search) begin
         raddr = '0;
      end else if (cmd.shift_step) begin
         raddr = idx_ff + IW'(2);
      end
   end

   always_comb begin
      wen   = cmd.append || cmd.shift_step;
      waddr = cmd.shift_step ? idx_ff : IW'(count_ff);
      wdata = cmd.shift_step ? rdata_ff : key_ff;
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_read_in   = res_read_ff;
      res_found_in  = res_found_ff;
      if (cmd.capture) begin
         res_status_in = ST_OK;
         res_read_in   = '0;
         res_found_in  = '0;
      end
      if (cmd.append) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.dec_count) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.set_miss) begin
         res_status_in = ST_MISS;
      end
      if (cmd.set_full) begin
         res_status_in = ST_FULL;
      end
      if (cmd.start_shift) begin
         idx_in = IW'(pos_ff - POS_W'(1));
      end
      if (cmd.start_search) begin
         idx_in = '0;
      end
      if (cmd.shift_step || cmd.search_step) begin
         idx_in = idx_ff + IW'(1);
      end
      if (cmd.take_read) begin
         res_read_in = rdata_ff;
      end
      if (cmd.take_found) begin
         res_found_in = POS_W'(idx_x + XW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_read_ff   <= res_read_in;
      res_found_ff  <= res_found_in;
      if (cmd.capture) begin
         op_ff  <= ole_op_type'(req_tdata[1:0]);
         pos_ff <= req_tdata[6:2];
         key_ff <= req_tdata[38:7];
      end
      if (cmd.publish) begin
         rsp_data_ff <= {4'b0000, POS_W'(count_ff), res_found_ff, res_read_ff,
                         res_status_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !sts.full)
      else $error("append issued on a full list");

   a_shift_inside: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_step |-> ((idx_x + XW'(1)) < count_x))
      else $error("shift writes outside the held entries");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cmd.dec_count |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("remove did not drop the count by one");

endmodule
`default_nettype wire

// ===== rtl/ole_ctrl.sv =====
// Controller of the ordered list engine: request sequencing and result handshake.
`default_nettype none
module ole_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire ole_pkg::ole_sts_type sts,
   output ole_pkg::ole_cmd_type      cmd
);
   import ole_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ_WAIT,
      S_SHIFT,
      S_SEARCH,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            case (sts.op)
               OP_APPEND: begin
                  if (sts.full) begin
                     cmd.set_full = 1'b1;
                  end else begin
                     cmd.append = 1'b1;
                  end
               end
               OP_READ: begin
                  if (!sts.pos_ok) begin
                     cmd.set_miss = 1'b1;
                  end else begin
                     cmd.start_read = 1'b1;
                     state_in       = S_READ_WAIT;
                  end
               end
               OP_REMOVE: begin
                  if (!sts.pos_ok) begin
                     cmd.set_miss = 1'b1;
                  end else if (sts.shift_more) begin
                     cmd.start_shift = 1'b1;
                     state_in        = S_SHIFT;
                  end else begin
                     cmd.dec_count = 1'b1;
                  end
               end
               OP_SEARCH: begin
                  if (sts.empty) begin
                     cmd.set_miss = 1'b1;
                  end else begin
                     cmd.start_search = 1'b1;
                     state_in         = S_SEARCH;
                  end
               end
               default: begin
                  cmd.set_miss = 1'b1;
               end
            endcase
         end
         S_READ_WAIT: begin
            cmd.take_read = 1'b1;
            state_in      = S_FINISH;
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (!sts.shift_cont) begin
               cmd.dec_count = 1'b1;
               state_in      = S_FINISH;
            end
         end
         S_SEARCH: begin
            if (sts.match) begin
               cmd.take_found = 1'b1;
               state_in       = S_FINISH;
            end else if (sts.search_more) begin
               cmd.search_step = 1'b1;
            end else begin
               cmd.set_miss = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.publish   = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in progress");

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_tvalid)
      else $error("published result not presented");

endmodule
`default_nettype wire

// ===== rtl/ordered_list_engine.sv =====
// Top level of the ordered list engine: bounded list with append, read, remove and search.
// One request is handled at a time: remove shifts the later entries down and search scans from
// the front, one entry per cycle; a result left waiting in the output register holds the next
// request in its final state.
// Reset (synchronous, active high) empties the list; entry storage is not cleared.
`default_nettype none
module ordered_list_engine (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // opcode[1:0], position[6:2], item_value[38:7], zero fill
   input  wire logic [ole_pkg::REQ_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // status[1:0], read_value[33:2], found_position[38:34], entry_count[43:39], zero fill
   output logic [ole_pkg::RSP_W-1:0]      rsp_tdata
);
   import ole_pkg::*;

   ole_cmd_type cmd;
   ole_sts_type sts;

   ole_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ole_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== tb/tb_ordered_list_engine.sv =====
// Testbench for ordered_list_engine: directed and random requests checked against a list predictor.
`default_nettype none
module tb_ordered_list_engine;
   import ole_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      ole_status_type status;
      logic [31:0]    read_value;
      logic [4:0]     found_position;
      logic [4:0]     entry_count;
   } list_outcome_t;

   typedef enum int {
      TREND_GROW,
      TREND_SHRINK,
      TREND_MIXED
   } trend_t;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   logic [31:0]   held_vals [CAPACITY];
   int            held_count = 0;
   list_outcome_t pending_outcomes [$];

   int cycle_count    = 0;
   int mismatch_count = 0;
   int rx_stall_left  = 0;
   int rx_hold_left   = 0;
   bit tx_idle_on     = 1'b1;
   bit rx_idle_on     = 1'b1;

   int sent_count     = 0;
   int op_tally [4]   = '{0, 0, 0, 0};
   int full_tally     = 0;
   int miss_tally     = 0;
   int result_count   = 0;

   ordered_list_engine DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic list_outcome_t apply_request(ole_op_type op, logic [4:0] pos,
                                                   logic [31:0] val);
      list_outcome_t r;
      bit            in_range;
      r.status         = ST_OK;
      r.read_value     = '0;
      r.found_position = '0;
      in_range = (int'(pos) >= 1) && (int'(pos) <= held_count);
      case (op)
         OP_APPEND: begin
            if (held_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               held_vals[held_count] = val;
               held_count++;
            end
         end
         OP_READ: begin
            if (in_range) r.read_value = held_vals[int'(pos) - 1];
            else r.status = ST_MISS;
         end
         OP_REMOVE: begin
            if (in_range) begin
               for (int i = int'(pos) - 1; i + 1 < held_count; i++)
                  held_vals[i] = held_vals[i + 1];
               held_count--;
            end else begin
               r.status = ST_MISS;
            end
         end
         default: begin
            r.status = ST_MISS;
            for (int i = 0; i < held_count; i++) begin
               if (r.status == ST_MISS && held_vals[i] == val) begin
                  r.found_position = 5'(i + 1);
                  r.status         = ST_OK;
               end
            end
         end
      endcase
      r.entry_count = 5'(held_count);
      return r;
   endfunction

   task automatic send_request(ole_op_type op, logic [4:0] pos, logic [31:0] val);
      int            gap;
      list_outcome_t outcome;
      gap = tx_idle_on ? $urandom_range(0, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {1'b0, val, pos, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      outcome = apply_request(op, pos, val);
      pending_outcomes.push_back(outcome);
      sent_count++;
      op_tally[int'(op)]++;
      if (outcome.status == ST_FULL) full_tally++;
      if (outcome.status == ST_MISS) miss_tally++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      list_outcome_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         rx_stall_left = rx_idle_on ? $urandom_range(0, 14) : 0;
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result: expected none, actual %0h", $time, rsp_tdata);
         end else begin
            want = pending_outcomes.pop_front();
            report_field("status", 32'(want.status), 32'(rsp_tdata[1:0]));
            report_field("read_value", want.read_value, rsp_tdata[33:2]);
            report_field("found_position", 32'(want.found_position), 32'(rsp_tdata[38:34]));
            report_field("entry_count", 32'(want.entry_count), 32'(rsp_tdata[43:39]));
         end
      end
   end

   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rx_hold_left--;
      end else if (rx_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rx_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return 32'($urandom_range(0, 7));
         4: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [4:0] pick_position();
      if (held_count > 0 && $urandom_range(0, 9) < 8)
         return 5'($urandom_range(1, held_count));
      if ($urandom_range(0, 1) == 0 || held_count >= CAPACITY)
         return 5'd0;
      return 5'($urandom_range(held_count + 1, CAPACITY));
   endfunction

   function automatic logic [31:0] pick_search_value();
      if (held_count > 0 && $urandom_range(0, 9) < 7)
         return held_vals[$urandom_range(0, held_count - 1)];
      return pick_value();
   endfunction

   function automatic ole_op_type pick_op(trend_t trend);
      int roll;
      roll = $urandom_range(0, 99);
      case (trend)
         TREND_GROW:   return roll < 50 ? OP_APPEND : roll < 70 ? OP_READ :
                              roll < 85 ? OP_REMOVE : OP_SEARCH;
         TREND_SHRINK: return roll < 15 ? OP_APPEND : roll < 35 ? OP_READ :
                              roll < 80 ? OP_REMOVE : OP_SEARCH;
         default:      return roll < 30 ? OP_APPEND : roll < 55 ? OP_READ :
                              roll < 75 ? OP_REMOVE : OP_SEARCH;
      endcase
   endfunction

   task automatic test_empty_list();
      send_request(OP_READ, 5'd0, 32'd0);
      send_request(OP_REMOVE, 5'd1, 32'd0);
      send_request(OP_SEARCH, 5'd0, 32'd0);
   endtask

   task automatic test_single_entry();
      send_request(OP_APPEND, 5'd0, 32'hDEAD_BEEF);
      send_request(OP_REMOVE, 5'd1, 32'd0);
      send_request(OP_READ, 5'd1, 32'd0);
   endtask

   task automatic test_fill_to_capacity();
      logic [31:0] fill [CAPACITY];
      fill = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
               32'h5A5A_5A5A, 32'h0000_0001, 32'hA5A5_A5A5, 32'h0F0F_0F0F,
               32'h5A5A_5A5A, 32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC,
               32'h1357_9BDF, 32'h2468_ACE0, 32'h5555_5555, 32'hAAAA_AAAA};
      foreach (fill[i]) send_request(OP_APPEND, 5'(i), fill[i]);
   endtask

   task automatic test_full_list_access();
      send_request(OP_APPEND, 5'd0, 32'h1111_1111);
      send_request(OP_READ, 5'd16, 32'd0);
      send_request(OP_READ, 5'd0, 32'hFFFF_FFFF);
      send_request(OP_SEARCH, 5'd0, 32'h5A5A_5A5A);
      send_request(OP_SEARCH, 5'd31, 32'h1234_5678);
      send_request(OP_REMOVE, 5'd16, 32'd0);
      send_request(OP_REMOVE, 5'd1, 32'd0);
      send_request(OP_READ, 5'd16, 32'd0);
   endtask

   task automatic test_backpressure();
      wait_for_results();
      tx_idle_on = 1'b0;
      rx_hold_left = 300;
      for (int i = 0; i < 12; i++) send_request(pick_op(TREND_MIXED), pick_position(),
                                                pick_value());
      wait_for_results();
      tx_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      trend_t     trend;
      ole_op_type op;
      for (int blk = 0; blk < 25; blk++) begin
         trend = trend_t'($urandom_range(0, 2));
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 50; i++) begin
            op = pick_op(trend);
            if (op == OP_SEARCH) send_request(op, 5'($urandom_range(0, 16)), pick_search_value());
            else send_request(op, pick_position(), pick_value());
         end
         if (blk % 6 == 5) wait_for_results();
      end
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      held_count = 0;
      test_empty_list();
      test_single_entry();
      test_fill_to_capacity();
      test_full_list_access();
      test_backpressure();
      test_random_traffic();
      wait_for_results();
      repeat (CAPACITY + 8) @(posedge clock);
      $display("Covered %0d requests: %0d append, %0d read, %0d remove, %0d search.",
               sent_count, op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
      $display("Saw %0d results, %0d full-list appends, %0d misses, %0d mismatches.",
               result_count, full_tally, miss_tally, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== ordered_list_engine.f =====
rtl/ole_pkg.sv
rtl/ole_dpath.sv
rtl/ole_ctrl.sv
rtl/ordered_list_engine.sv
tb/tb_ordered_list_engine.sv
